[src/qau_pkg.sv]
package qau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int TOL_WIDTH  = 24;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W - FRAC_BITS + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_MUL,
        OP_SCALE,
        OP_CONJ,
        OP_NORM,
        OP_NORMALIZE,
        OP_INVERSE,
        OP_ROTATE
    } op_t;

    typedef logic [3:0][DATA_WIDTH-1:0] quat_t;
    typedef logic [3:0][DATA_WIDTH:0]   wquat_t;

    typedef struct packed {
        op_t    op;
        quat_t  a;
        quat_t  b;
        wquat_t t;
        quat_t  m;
    } entry_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } sat_t;

    function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
        sat_t res;
        res.ovf = 1'b0;
        res.val = v[DATA_WIDTH-1:0];
        if (v > SUM_MAX)
        begin
            res.ovf = 1'b1;
            res.val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else if (v < SUM_MIN)
        begin
            res.ovf = 1'b1;
            res.val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        return res;
    endfunction

    function automatic logic signed [SUM_W-1:0] sx(input logic [DATA_WIDTH-1:0] x);
        return {{(SUM_W-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
    endfunction

    function automatic logic signed [SUM_W-1:0] sxw(input logic [DATA_WIDTH:0] x);
        return {{(SUM_W-DATA_WIDTH-1){x[DATA_WIDTH]}}, x};
    endfunction

endpackage

[src/qau_if.sv]
interface qau_cmd_if import qau_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [2:0]                   operation;
    logic signed [DATA_WIDTH-1:0] a_w;
    logic signed [DATA_WIDTH-1:0] a_x;
    logic signed [DATA_WIDTH-1:0] a_y;
    logic signed [DATA_WIDTH-1:0] a_z;
    logic signed [DATA_WIDTH-1:0] b_w;
    logic signed [DATA_WIDTH-1:0] b_x;
    logic signed [DATA_WIDTH-1:0] b_y;
    logic signed [DATA_WIDTH-1:0] b_z;

    modport source (output valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink (input valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

interface qau_rsp_if import qau_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] r_w;
    logic signed [DATA_WIDTH-1:0] r_x;
    logic signed [DATA_WIDTH-1:0] r_y;
    logic signed [DATA_WIDTH-1:0] r_z;
    logic [1:0]                   status;

    modport source (output valid, r_w, r_x, r_y, r_z, status, input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, status, output ready);
endinterface

[src/qau_front.sv]
module qau_front import qau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    qau_cmd_if.sink  cmd,
    output logic     push_valid,
    input  logic     push_ready,
    output entry_t   push_entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   take;

    assign cmd.ready  = !valid_reg || push_ready;
    assign take       = cmd.valid && cmd.ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    // conjugate ahead of the norm for inverse and rotate, magnitudes for the squares
    always_comb
    begin
        logic                  neg;
        logic [DATA_WIDTH:0]   tx;
        logic [DATA_WIDTH:0]   tn;
        entry_next.op = op_t'(cmd.operation);
        entry_next.a  = {cmd.a_z, cmd.a_y, cmd.a_x, cmd.a_w};
        entry_next.b  = {cmd.b_z, cmd.b_y, cmd.b_x, cmd.b_w};
        neg = entry_next.op inside {OP_INVERSE, OP_ROTATE};
        for (int i = 0; i < 4; i++)
        begin
            tx = {entry_next.a[i][DATA_WIDTH-1], entry_next.a[i]};
            entry_next.t[i] = (neg && i != 0) ? -tx : tx;
            tn = -entry_next.t[i];
            entry_next.m[i] = entry_next.t[i][DATA_WIDTH] ? tn[DATA_WIDTH-1:0]
                                                          : entry_next.t[i][DATA_WIDTH-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

[src/qau_fifo.sv]
module qau_fifo import qau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  entry_t in_entry,
    output logic   out_valid,
    input  logic   out_ready,
    output entry_t out_entry
);

    entry_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = count_reg != (FIFO_AW+1)'(FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_entry = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[src/qau_hamilton.sv]
module qau_hamilton import qau_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  quat_t p,
    input  quat_t q,
    output quat_t r,
    output logic  ovf
);

    logic signed [PROD_W-1:0] prod_reg  [16];
    logic signed [PROD_W-1:0] prod_next [16];
    quat_t                    r_reg;
    quat_t                    r_next;
    logic                     ovf_reg;
    logic                     ovf_next;

    assign r   = r_reg;
    assign ovf = ovf_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[4*i+j] = $signed(p[i]) * $signed(q[j]);
            end
        end
    end

    // floor of each product, exact sums, clamp at the end
    always_comb
    begin
        logic signed [PROD_W-1:0] shr;
        logic signed [SUM_W-1:0]  f [16];
        logic signed [SUM_W-1:0]  s [4];
        sat_t                     sr;
        for (int k = 0; k < 16; k++)
        begin
            shr  = prod_reg[k] >>> FRAC_BITS;
            f[k] = $signed(shr[SUM_W-1:0]);
        end
        s[0] = f[0]  - f[5]  - f[10] - f[15];
        s[1] = f[1]  + f[4]  + f[11] - f[14];
        s[2] = f[2]  + f[8]  + f[13] - f[7];
        s[3] = f[3]  + f[12] + f[6]  - f[9];
        ovf_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            sr        = saturate(s[i]);
            r_next[i] = sr.val;
            ovf_next  = ovf_next | sr.ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            r_reg    <= r_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

[src/qau_back.sv]
module qau_back import qau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [TOL_WIDTH-1:0] tol,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  entry_t               in_entry,
    qau_rsp_if.source            rsp
);

    localparam int ROOT_STEPS = DATA_WIDTH;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int STG_SUM    = 2;
    localparam int STG_ROOT0  = STG_SUM + 1;
    localparam int STG_NORM   = STG_ROOT0 + ROOT_STEPS;
    localparam int STG_DIV0   = STG_NORM + 1;
    localparam int STG_UNIT   = STG_DIV0 + DIV_STEPS;
    localparam int STG_H1     = STG_UNIT + 3;
    localparam int DEPTH      = STG_UNIT + 4;

    localparam logic [DATA_WIDTH:0] NORM_ONE =
        {{(DATA_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] QUO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        op_t                             op;
        quat_t                           a;
        quat_t                           b;
        wquat_t                          t;
        quat_t                           m;
        logic [3:0][PROD_W-1:0]          sq;
        logic [PROD_W-1:0]               srem;
        logic [PROD_W-1:0]               root;
        logic                            carry;
        logic [DATA_WIDTH:0]             n;
        logic                            zero;
        logic                            unit;
        logic [3:0][DATA_WIDTH+1:0]      drem;
        logic [3:0][FRAC_BITS:0]         quo;
        wquat_t                          v;
        quat_t                           h1;
        logic                            h1_ovf;
    } pipe_t;

    pipe_t                pipe_reg  [1:DEPTH];
    pipe_t                pipe_next [1:DEPTH];
    logic [DEPTH:1]       valid_reg;
    logic                 out_valid_reg;
    quat_t                r_reg;
    quat_t                r_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic                 adv;
    quat_t                h1_p;
    quat_t                h1_q;
    quat_t                h1_r;
    logic                 h1_ovf;
    quat_t                h2_r;
    logic                 h2_ovf;

    assign adv       = !out_valid_reg || rsp.ready;
    assign in_ready  = adv;
    assign rsp.valid = out_valid_reg;
    assign rsp.r_w   = r_reg[0];
    assign rsp.r_x   = r_reg[1];
    assign rsp.r_y   = r_reg[2];
    assign rsp.r_z   = r_reg[3];
    assign rsp.status = status_reg;

    always_comb
    begin
        logic [PROD_W:0]         sqsum;
        logic [PROD_W-1:0]       rbit;
        logic [PROD_W-1:0]       trial;
        logic [DATA_WIDTH:0]     nval;
        logic [DATA_WIDTH:0]     diff;
        logic [DATA_WIDTH:0]     tol_ext;
        logic [DATA_WIDTH+1:0]   cand;
        logic [DATA_WIDTH+1:0]   nd;
        logic [DATA_WIDTH:0]     qext;

        pipe_next[1]    = '0;
        pipe_next[1].op = in_entry.op;
        pipe_next[1].a  = in_entry.a;
        pipe_next[1].b  = in_entry.b;
        pipe_next[1].t  = in_entry.t;
        pipe_next[1].m  = in_entry.m;
        for (int i = 0; i < 4; i++)
        begin
            pipe_next[1].sq[i] = in_entry.m[i] * in_entry.m[i];
        end
        for (int k = 2; k <= DEPTH; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // sum of squares, the top bit only at the largest magnitudes
        sqsum = {1'b0, pipe_reg[1].sq[0]} + {1'b0, pipe_reg[1].sq[1]}
              + {1'b0, pipe_reg[1].sq[2]} + {1'b0, pipe_reg[1].sq[3]};
        pipe_next[STG_SUM].srem  = sqsum[PROD_W-1:0];
        pipe_next[STG_SUM].carry = sqsum[PROD_W];
        pipe_next[STG_SUM].root  = '0;

        // square root, one result bit per stage
        for (int s = 0; s < ROOT_STEPS; s++)
        begin
            rbit = '0;
            rbit[PROD_W-2-2*s] = 1'b1;
            trial = pipe_reg[STG_ROOT0+s-1].root + rbit;
            if (pipe_reg[STG_ROOT0+s-1].srem >= trial)
            begin
                pipe_next[STG_ROOT0+s].srem = pipe_reg[STG_ROOT0+s-1].srem - trial;
                pipe_next[STG_ROOT0+s].root = (pipe_reg[STG_ROOT0+s-1].root >> 1) + rbit;
            end
            else
            begin
                pipe_next[STG_ROOT0+s].root = pipe_reg[STG_ROOT0+s-1].root >> 1;
            end
        end

        nval = pipe_reg[STG_NORM-1].carry ? {1'b1, {DATA_WIDTH{1'b0}}}
                                          : pipe_reg[STG_NORM-1].root[DATA_WIDTH:0];
        tol_ext = {{(DATA_WIDTH+1-TOL_WIDTH){1'b0}}, tol};
        diff = (nval >= NORM_ONE) ? nval - NORM_ONE : NORM_ONE - nval;
        pipe_next[STG_NORM].n    = nval;
        pipe_next[STG_NORM].zero = nval <= tol_ext;
        pipe_next[STG_NORM].unit = diff <= tol_ext;
        for (int i = 0; i < 4; i++)
        begin
            pipe_next[STG_NORM].drem[i] = {2'b00, 1'b0, pipe_reg[STG_NORM-1].m[i][DATA_WIDTH-1:1]};
            pipe_next[STG_NORM].quo[i]  = '0;
        end

        // restoring division, quotient never above one
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            nd = {1'b0, pipe_reg[STG_DIV0+j-1].n};
            for (int i = 0; i < 4; i++)
            begin
                cand = {pipe_reg[STG_DIV0+j-1].drem[i][DATA_WIDTH:0],
                        (j == 0) ? pipe_reg[STG_DIV0+j-1].m[i][0] : 1'b0};
                if (cand >= nd)
                begin
                    pipe_next[STG_DIV0+j].drem[i] = cand - nd;
                    pipe_next[STG_DIV0+j].quo[i][FRAC_BITS-j] = 1'b1;
                end
                else
                begin
                    pipe_next[STG_DIV0+j].drem[i] = cand;
                end
            end
        end

        for (int i = 0; i < 4; i++)
        begin
            qext = {{(DATA_WIDTH-FRAC_BITS){1'b0}}, pipe_reg[STG_UNIT-1].quo[i]};
            if (pipe_reg[STG_UNIT-1].zero)
            begin
                pipe_next[STG_UNIT].v[i] = '0;
            end
            else if (pipe_reg[STG_UNIT-1].unit)
            begin
                pipe_next[STG_UNIT].v[i] = pipe_reg[STG_UNIT-1].t[i];
            end
            else
            begin
                pipe_next[STG_UNIT].v[i] = pipe_reg[STG_UNIT-1].t[i][DATA_WIDTH] ? -qext : qext;
            end
        end

        pipe_next[STG_H1].h1     = h1_r;
        pipe_next[STG_H1].h1_ovf = h1_ovf;
    end

    // first product: a*b, a scaled by b_w, or b with w cleared times the unit inverse
    always_comb
    begin
        h1_p = pipe_reg[STG_UNIT].a;
        h1_q = pipe_reg[STG_UNIT].b;
        case (pipe_reg[STG_UNIT].op)
            OP_SCALE:
            begin
                h1_q    = '0;
                h1_q[0] = pipe_reg[STG_UNIT].b[0];
            end
            OP_ROTATE:
            begin
                h1_p    = pipe_reg[STG_UNIT].b;
                h1_p[0] = '0;
                for (int i = 0; i < 4; i++)
                begin
                    h1_q[i] = pipe_reg[STG_UNIT].v[i][DATA_WIDTH-1:0];
                end
            end
            default:
            begin
                h1_p = pipe_reg[STG_UNIT].a;
            end
        endcase
    end

    qau_hamilton u_ham1
    (
        .clk (clk),
        .en  (adv),
        .p   (h1_p),
        .q   (h1_q),
        .r   (h1_r),
        .ovf (h1_ovf)
    );

    qau_hamilton u_ham2
    (
        .clk (clk),
        .en  (adv),
        .p   (pipe_reg[STG_UNIT+2].a),
        .q   (h1_r),
        .r   (h2_r),
        .ovf (h2_ovf)
    );

    always_comb
    begin
        logic signed [SUM_W-1:0] val [4];
        logic                    ovf;
        logic                    zf;
        sat_t                    sr;
        ovf = 1'b0;
        zf  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            val[i] = '0;
        end
        case (pipe_reg[DEPTH].op)
            OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    val[i] = sx(pipe_reg[DEPTH].a[i]) + sx(pipe_reg[DEPTH].b[i]);
                end
            end
            OP_MUL, OP_SCALE:
            begin
                ovf = pipe_reg[DEPTH].h1_ovf;
                for (int i = 0; i < 4; i++)
                begin
                    val[i] = sx(pipe_reg[DEPTH].h1[i]);
                end
            end
            OP_CONJ:
            begin
                val[0] = sx(pipe_reg[DEPTH].a[0]);
                for (int i = 1; i < 4; i++)
                begin
                    val[i] = -sx(pipe_reg[DEPTH].a[i]);
                end
            end
            OP_NORM:
            begin
                val[0] = {{(SUM_W-DATA_WIDTH-1){1'b0}}, pipe_reg[DEPTH].n};
            end
            OP_NORMALIZE, OP_INVERSE:
            begin
                zf = pipe_reg[DEPTH].zero;
                for (int i = 0; i < 4; i++)
                begin
                    val[i] = sxw(pipe_reg[DEPTH].v[i]);
                end
            end
            OP_ROTATE:
            begin
                zf = pipe_reg[DEPTH].zero;
                if (!pipe_reg[DEPTH].zero)
                begin
                    ovf = pipe_reg[DEPTH].h1_ovf | h2_ovf;
                    for (int i = 1; i < 4; i++)
                    begin
                        val[i] = sx(h2_r[i]);
                    end
                end
            end
            default:
            begin
                zf = 1'b0;
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            sr        = saturate(val[i]);
            r_next[i] = sr.val;
            ovf       = ovf | sr.ovf;
        end
        if (zf)
        begin
            status_next = STATUS_ZERO;
        end
        else if (ovf)
        begin
            status_next = STATUS_SAT;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[DEPTH-1:1], in_valid};
            out_valid_reg <= valid_reg[DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg   <= pipe_next;
            r_reg      <= r_next;
            status_reg <= status_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved during a stall");

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_UNIT-1] && !pipe_reg[STG_UNIT-1].zero |->
            pipe_reg[STG_UNIT-1].quo[0] <= QUO_ONE && pipe_reg[STG_UNIT-1].quo[1] <= QUO_ONE &&
            pipe_reg[STG_UNIT-1].quo[2] <= QUO_ONE && pipe_reg[STG_UNIT-1].quo[3] <= QUO_ONE)
        else $error("normalized part above one");

    a_norm_vector_zero: assert property (@(posedge clk) disable iff (!rst_n)
        adv && valid_reg[DEPTH] && pipe_reg[DEPTH].op == OP_NORM |=>
            rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0)
        else $error("norm result carries vector part");

    a_zero_norm_status: assert property (@(posedge clk) disable iff (!rst_n)
        adv && valid_reg[DEPTH] && pipe_reg[DEPTH].zero &&
        (pipe_reg[DEPTH].op == OP_NORMALIZE || pipe_reg[DEPTH].op == OP_INVERSE ||
         pipe_reg[DEPTH].op == OP_ROTATE) |=>
            rsp.status == STATUS_ZERO && rsp.r_w == '0)
        else $error("zero norm not reported");

endmodule

[src/quaternion_arithmetic_unit.sv]
// channel   dir  beat
// cmd       in   operation, a_w..a_z, b_w..b_z
// rsp       out  r_w..r_z, status
// cfg       in   cfg_we, cfg_wdata (unit_tolerance)
//
// one beat per cycle sustained while rsp is not stalled
// the back pipe holds the 32-step square root pipe and the 25-step divider pipe
// cmd stays ready while the 4-entry queue between front and back has room
// a stalled rsp freezes the back pipe; the front keeps filling the queue
// reset clears all valids and loads tolerance 1
module quaternion_arithmetic_unit import qau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TOL_WIDTH-1:0] cfg_wdata,
    qau_cmd_if.sink              cmd,
    qau_rsp_if.source            rsp
);

    logic [TOL_WIDTH-1:0] tol_reg;
    logic                 push_valid;
    logic                 push_ready;
    entry_t               push_entry;
    logic                 pop_valid;
    logic                 pop_ready;
    entry_t               pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    qau_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    qau_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_entry (pop_entry)
    );

    qau_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tol      (tol_reg),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_entry (pop_entry),
        .rsp      (rsp)
    );

endmodule

[dv/qau_checker.sv]
`timescale 1ns / 1ps
module qau_checker import qau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TOL_WIDTH-1:0] cfg_wdata,
    qau_cmd_if                   cmd,
    qau_rsp_if                   rsp,
    output int                   fail_count,
    output int                   pending,
    output int                   rsp_seen
);
    typedef longint q4_t[4];

    typedef struct {
        logic [DATA_WIDTH-1:0] w;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
        logic [DATA_WIDTH-1:0] z;
        logic [1:0]            st;
    } qres_t;

    localparam longint DMAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint DMIN = -DMAX - 1;
    localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;

    qres_t          expected_q[$];
    logic [63:0]    tol;

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp(longint v, ref bit flag);
        if (v > DMAX)
        begin
            flag = 1;
            return DMAX;
        end
        if (v < DMIN)
        begin
            flag = 1;
            return DMIN;
        end
        return v;
    endfunction

    function automatic void hprod(input q4_t p, input q4_t q, output q4_t r, ref bit flag);
        r[0] = clamp(qmul(p[0], q[0]) - qmul(p[1], q[1]) - qmul(p[2], q[2])
                     - qmul(p[3], q[3]), flag);
        r[1] = clamp(qmul(p[0], q[1]) + qmul(p[1], q[0]) + qmul(p[2], q[3])
                     - qmul(p[3], q[2]), flag);
        r[2] = clamp(qmul(p[0], q[2]) + qmul(p[2], q[0]) + qmul(p[3], q[1])
                     - qmul(p[1], q[3]), flag);
        r[3] = clamp(qmul(p[0], q[3]) + qmul(p[3], q[0]) + qmul(p[1], q[2])
                     - qmul(p[2], q[1]), flag);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] quat_norm(q4_t q);
        logic [64:0] s;
        logic [63:0] m;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            m = q[i] < 0 ? -q[i] : q[i];
            s += m * m;
        end
        if (s[64])
            return 64'd1 << 32;
        return int_sqrt(s[63:0]);
    endfunction

    function automatic bit unit_scale(input q4_t q, output q4_t r);
        logic [63:0] n;
        logic [63:0] diff;
        logic [63:0] d;
        logic [63:0] m;
        n = quat_norm(q);
        diff = n > ONE_Q ? n - ONE_Q : ONE_Q - n;
        if (n <= tol)
        begin
            for (int i = 0; i < 4; i++)
                r[i] = 0;
            return 1;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (diff <= tol)
                r[i] = q[i];
            else
            begin
                m = q[i] < 0 ? -q[i] : q[i];
                d = (m << FRAC_BITS) / n;
                r[i] = q[i] < 0 ? -longint'(d) : longint'(d);
            end
        end
        return 0;
    endfunction

    function automatic qres_t quat_result(op_t op, q4_t a, q4_t b);
        q4_t r;
        q4_t t;
        q4_t u;
        qres_t e;
        bit flag;
        bit zero;
        logic [63:0] n;
        flag = 0;
        zero = 0;
        for (int i = 0; i < 4; i++)
            r[i] = 0;
        t[0] = a[0];
        for (int i = 1; i < 4; i++)
            t[i] = -a[i];
        case (op)
            OP_ADD:
                for (int i = 0; i < 4; i++)
                    r[i] = a[i] + b[i];
            OP_MUL:
                hprod(a, b, r, flag);
            OP_SCALE:
                for (int i = 0; i < 4; i++)
                    r[i] = qmul(a[i], b[0]);
            OP_CONJ:
                r = t;
            OP_NORM:
            begin
                n = quat_norm(a);
                r[0] = n > DMAX ? DMAX + 1 : longint'(n);
            end
            OP_NORMALIZE:
                zero = unit_scale(a, r);
            OP_INVERSE:
                zero = unit_scale(t, r);
            default:
            begin
                zero = unit_scale(t, u);
                if (!zero)
                begin
                    b[0] = 0;
                    hprod(b, u, t, flag);
                    hprod(a, t, r, flag);
                    r[0] = 0;
                end
            end
        endcase
        e.w = DATA_WIDTH'(clamp(r[0], flag));
        e.x = DATA_WIDTH'(clamp(r[1], flag));
        e.y = DATA_WIDTH'(clamp(r[2], flag));
        e.z = DATA_WIDTH'(clamp(r[3], flag));
        e.st = zero ? STATUS_ZERO : (flag ? STATUS_SAT : STATUS_OK);
        return e;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("error: result %0d %s got %h want %h", rsp_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        q4_t a;
        q4_t b;
        qres_t e;
        if (!rst_n)
        begin
            tol <= 64'(TOL_RESET);
            fail_count <= 0;
            rsp_seen <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                tol <= 64'(cfg_wdata);
            if (rsp.valid && rsp.ready)
            begin
                rsp_seen <= rsp_seen + 1;
                if (expected_q.size() == 0)
                    report("unexpected beat", 0, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp.r_w !== e.w) report("r_w", rsp.r_w, e.w);
                    if (rsp.r_x !== e.x) report("r_x", rsp.r_x, e.x);
                    if (rsp.r_y !== e.y) report("r_y", rsp.r_y, e.y);
                    if (rsp.r_z !== e.z) report("r_z", rsp.r_z, e.z);
                    if (rsp.status !== e.st) report("status", rsp.status, e.st);
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                a = '{cmd.a_w, cmd.a_x, cmd.a_y, cmd.a_z};
                b = '{cmd.b_w, cmd.b_x, cmd.b_y, cmd.b_z};
                expected_q.push_back(quat_result(op_t'(cmd.operation), a, b));
            end
            pending <= expected_q.size();
        end
    end
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import qau_pkg::*;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 cfg_we = 0;
    logic [TOL_WIDTH-1:0] cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    int                   rsp_seen;
    int                   sent = 0;
    bit                   hold_off = 0;
    bit                   sink_stall = 1;

    qau_cmd_if cmd ();
    qau_rsp_if rsp ();

    quaternion_arithmetic_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    qau_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .rsp_seen   (rsp_seen)
    );

    always #5 clk = ~clk;

    initial
    begin
        cmd.valid = 0;
        cmd.operation = '0;
        {cmd.a_w, cmd.a_x, cmd.a_y, cmd.a_z} = '0;
        {cmd.b_w, cmd.b_x, cmd.b_y, cmd.b_z} = '0;
        rsp.ready = 0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 2 ** 25)) - 2 ** 24);
            3: return 32'h01000000;
            4: return 32'hff000000;
            5: return '0;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after a beat so that the next one can follow at once
    task automatic send(op_t op, logic [31:0] aw, ax, ay, az, bw, bx, by, bz);
        int g;
        g = sink_stall ? gap_len() : 0;
        if (g > 0)
        begin
            cmd.valid <= 0;
            repeat (g) @(posedge clk);
        end
        cmd.valid <= 1;
        cmd.operation <= op;
        cmd.a_w <= aw;
        cmd.a_x <= ax;
        cmd.a_y <= ay;
        cmd.a_z <= az;
        cmd.b_w <= bw;
        cmd.b_x <= bx;
        cmd.b_y <= by;
        cmd.b_z <= bz;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_random(int count);
        logic [31:0] p[8];
        int s;
        for (int k = 0; k < count; k++)
        begin
            s = $urandom_range(0, 3);
            foreach (p[i])
            begin
                if (s == 0)
                    p[i] = rand_part();
                else
                    p[i] = 32'(signed'($urandom_range(0, 2 ** (12 + 4 * s)))
                               - 2 ** (11 + 4 * s));
            end
            send(op_t'($urandom_range(0, 7)), p[0], p[1], p[2], p[3],
                 p[4], p[5], p[6], p[7]);
        end
    endtask

    task automatic drain();
        cmd.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [TOL_WIDTH-1:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    always @(posedge clk)
    begin
        if (hold_off || (sink_stall && $urandom_range(0, 9) < 3))
            rsp.ready <= 0;
        else
            rsp.ready <= 1;
    end

    initial
    begin
        logic [31:0] one;
        logic [31:0] half;
        one = 32'h01000000;
        half = 32'h00800000;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int o = 0; o < 8; o++)
        begin
            send(op_t'(o), 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
            send(op_t'(o), half, half, half, half, one, one, '0, 32'hff000000);
        end
        send(OP_NORMALIZE, '0, '0, '0, 32'd1, '0, '0, '0, '0);
        send(OP_INVERSE, '0, '0, '0, '0, '0, '0, '0, '0);
        send(OP_ROTATE, '0, 32'd1, '0, '0, one, one, one, one);
        send(OP_NORMALIZE, one + 1, '0, '0, '0, '0, '0, '0, '0);
        send(OP_NORMALIZE, one + 2, '0, '0, '0, '0, '0, '0, '0);
        send(OP_ROTATE, half, half, half, half, '0, one, '0, '0);
        send(OP_MUL, one, '0, '0, '0, one, 32'h7fffffff, 32'h80000000, one);
        drain();

        set_tolerance(24'hffffff);
        send_random(40);
        drain();
        set_tolerance('0);
        send_random(40);
        drain();
        set_tolerance(24'h000100);
        hold_off = 1;
        fork
            send_random(120);
            begin
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
        join
        send_random(110);
        sink_stall = 0;
        send_random(60);
        sink_stall = 1;
        drain();
        set_tolerance(24'h100000);
        send_random(200);
        drain();

        $display("sent %0d commands, checked %0d results", sent, rsp_seen);
        $display("tolerance settings 1, max, 0, 256 and 2^20 with a long output stall");
        if (fail_count == 0)
            $display("quaternion_arithmetic_unit: match");
        else
            $display("quaternion_arithmetic_unit: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("quaternion_arithmetic_unit: mismatch");
        $finish;
    end
endmodule
